// ----- design/hsv_to_rgb_pixel_defines.svh -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel assertion macros
// shared check macros for the hsv to rgb pixel pipeline
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HSV2RGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_pixel: check failed");

// next-cycle implication, disabled while in reset
`define HSV2RGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_pixel: check failed");

`endif

// ----- design/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants and types for the hsv to rgb pixel pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // default number of fraction bits in hue, saturation and value
  localparam int FRAC_BITS_DEF = 12;

  // input field width
  localparam int CHAN_W = 16;
  // output channel width
  localparam int RGB_W = 8;

  // 3/pi in unsigned q0.24
  localparam int K_W = 24;
  localparam logic [K_W-1:0] THIRD_PI_Q24 = 24'd16021061;

  // scaled hue width: signed 16 bit times signed 25 bit
  localparam int X_W = CHAN_W + K_W + 1;

  // colour wheel sector
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

endpackage

// ----- design/hsv2rgb_front.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_front
// first stage: clamps saturation and value, scales hue by 3/pi
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_pixel_defines.svh"

module hsv2rgb_front #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] hue,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] saturation,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] brightness,
  output logic                                 s1_valid,
  input  logic                                 s1_ready,
  output logic signed [hsv2rgb_pkg::X_W-1:0]    s1_x,
  output logic        [FRAC_BITS:0]            s1_sat,
  output logic        [FRAC_BITS:0]            s1_bri
);
  import hsv2rgb_pkg::*;

  localparam int EXT_W = CHAN_W + 2;
  localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS:0] ONE_V = (FRAC_BITS+1)'(1 << FRAC_BITS);

  logic                    valid_r;
  logic signed [X_W-1:0]   x_r, x_nxt;
  logic [FRAC_BITS:0]      sat_r, sat_nxt;
  logic [FRAC_BITS:0]      bri_r, bri_nxt;
  logic signed [EXT_W-1:0] sat_ext, bri_ext;

  // clamp to 0..1
  always_comb begin
    sat_ext = EXT_W'(saturation);
    bri_ext = EXT_W'(brightness);
    if (sat_ext[EXT_W-1]) begin
      sat_nxt = '0;
    end else if (sat_ext > ONE_EXT) begin
      sat_nxt = ONE_V;
    end else begin
      sat_nxt = sat_ext[FRAC_BITS:0];
    end
    if (bri_ext[EXT_W-1]) begin
      bri_nxt = '0;
    end else if (bri_ext > ONE_EXT) begin
      bri_nxt = ONE_V;
    end else begin
      bri_nxt = bri_ext[FRAC_BITS:0];
    end
    x_nxt = X_W'(hue) * X_W'($signed({1'b0, THIRD_PI_Q24}));
  end

  assign in_ready = !valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r   <= x_nxt;
      sat_r <= sat_nxt;
      bri_r <= bri_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_x     = x_r;
  assign s1_sat   = sat_r;
  assign s1_bri   = bri_r;

  `HSV2RGB_ASSERT_IMP(a_clamped, clk, rst_n, valid_r, (sat_r <= ONE_V) && (bri_r <= ONE_V))

endmodule

// ----- design/hsv2rgb_terms.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_terms
// stages two and three: sector and fraction, p q t terms, channel select
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_pixel_defines.svh"

module hsv2rgb_terms #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  logic signed [hsv2rgb_pkg::X_W-1:0] s1_x,
  input  logic        [FRAC_BITS:0]         s1_sat,
  input  logic        [FRAC_BITS:0]         s1_bri,
  output logic                              s3_valid,
  input  logic                              s3_ready,
  output logic        [3*FRAC_BITS:0]       s3_red,
  output logic        [3*FRAC_BITS:0]       s3_green,
  output logic        [3*FRAC_BITS:0]       s3_blue
);
  import hsv2rgb_pkg::*;

  localparam int PW = 2*FRAC_BITS + 1;
  localparam int CW = 3*FRAC_BITS + 1;
  localparam int HUE_SHIFT = FRAC_BITS + K_W;
  localparam logic [FRAC_BITS:0] ONE_V = (FRAC_BITS+1)'(1 << FRAC_BITS);
  localparam logic [PW-1:0] ONE2 = PW'(1) << (2*FRAC_BITS);
  localparam logic [CW-1:0] ONE3 = CW'(1) << (3*FRAC_BITS);

  // stage two
  logic                 v2_r, rdy2;
  sector_t              sec2_r, sec2_nxt;
  logic [PW-1:0]        aq2_r, aq2_nxt, at2_r, at2_nxt, pv2_r, pv2_nxt;
  logic [FRAC_BITS:0]   bri2_r;
  logic [X_W-1:0]       sh;
  logic                 in_range;
  logic [FRAC_BITS-1:0] frac;

  // stage three
  logic          v3_r, rdy3;
  logic [CW-1:0] red3_r, red3_nxt, grn3_r, grn3_nxt, blu3_r, blu3_nxt;
  logic [CW-1:0] q3, t3, p3, vq3;

  // negative hue or a sector past five falls back to sector zero, fraction zero
  always_comb begin
    sh       = X_W'($unsigned(s1_x)) >> HUE_SHIFT;
    in_range = !s1_x[X_W-1] && (sh <= X_W'(SEC_5));
    sec2_nxt = in_range ? sector_t'(sh[2:0]) : SEC_0;
    frac     = in_range ? s1_x[K_W +: FRAC_BITS] : '0;
    aq2_nxt  = ONE2 - PW'(s1_sat) * PW'({1'b0, frac});
    at2_nxt  = ONE2 - PW'(s1_sat) * PW'(ONE_V - {1'b0, frac});
    pv2_nxt  = PW'(s1_bri) * PW'(ONE_V - s1_sat);
  end

  assign rdy3     = !v3_r || s3_ready;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      sec2_r <= sec2_nxt;
      aq2_r  <= aq2_nxt;
      at2_r  <= at2_nxt;
      pv2_r  <= pv2_nxt;
      bri2_r <= s1_bri;
    end
  end

  // p q t and full value, then route by sector
  always_comb begin
    q3  = CW'(bri2_r) * CW'(aq2_r);
    t3  = CW'(bri2_r) * CW'(at2_r);
    p3  = CW'(pv2_r) << FRAC_BITS;
    vq3 = CW'(bri2_r) << (2*FRAC_BITS);
    unique case (sec2_r)
      SEC_1: begin
        red3_nxt = q3;  grn3_nxt = vq3; blu3_nxt = p3;
      end
      SEC_2: begin
        red3_nxt = p3;  grn3_nxt = vq3; blu3_nxt = t3;
      end
      SEC_3: begin
        red3_nxt = p3;  grn3_nxt = q3;  blu3_nxt = vq3;
      end
      SEC_4: begin
        red3_nxt = t3;  grn3_nxt = p3;  blu3_nxt = vq3;
      end
      SEC_5: begin
        red3_nxt = vq3; grn3_nxt = p3;  blu3_nxt = q3;
      end
      default: begin
        red3_nxt = vq3; grn3_nxt = t3;  blu3_nxt = p3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      red3_r <= red3_nxt;
      grn3_r <= grn3_nxt;
      blu3_r <= blu3_nxt;
    end
  end

  assign s3_valid = v3_r;
  assign s3_red   = red3_r;
  assign s3_green = grn3_r;
  assign s3_blue  = blu3_r;

  `HSV2RGB_ASSERT_IMP(a_red_le_one, clk, rst_n, v3_r, red3_r <= ONE3)
  `HSV2RGB_ASSERT_IMP(a_grn_le_one, clk, rst_n, v3_r, grn3_r <= ONE3)
  `HSV2RGB_ASSERT_IMP(a_blu_le_one, clk, rst_n, v3_r, blu3_r <= ONE3)

endmodule

// ----- design/hsv2rgb_quant.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_quant
// output stage: scales each channel by 255, rounds half up, holds the word
// ----------------------------------------------------------------------------
module hsv2rgb_quant #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s3_valid,
  output logic                            s3_ready,
  input  logic [3*FRAC_BITS:0]            s3_red,
  input  logic [3*FRAC_BITS:0]            s3_green,
  input  logic [3*FRAC_BITS:0]            s3_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsv2rgb_pkg::RGB_W-1:0]   out_red,
  output logic [hsv2rgb_pkg::RGB_W-1:0]   out_green,
  output logic [hsv2rgb_pkg::RGB_W-1:0]   out_blue
);
  import hsv2rgb_pkg::*;

  localparam int OUT_SHIFT = 3*FRAC_BITS;
  localparam int SW = OUT_SHIFT + RGB_W + 1;
  localparam logic [SW-1:0] HALF = SW'(1) << (OUT_SHIFT - 1);

  logic             valid_r;
  logic [RGB_W-1:0] red_r, red_nxt, grn_r, grn_nxt, blu_r, blu_nxt;
  logic [SW-1:0]    red_s, grn_s, blu_s;

  // c*255 as (c << 8) - c
  always_comb begin
    red_s   = (SW'(s3_red) << RGB_W) - SW'(s3_red) + HALF;
    grn_s   = (SW'(s3_green) << RGB_W) - SW'(s3_green) + HALF;
    blu_s   = (SW'(s3_blue) << RGB_W) - SW'(s3_blue) + HALF;
    red_nxt = red_s[OUT_SHIFT +: RGB_W];
    grn_nxt = grn_s[OUT_SHIFT +: RGB_W];
    blu_nxt = blu_s[OUT_SHIFT +: RGB_W];
  end

  assign s3_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s3_ready) begin
      valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      red_r <= red_nxt;
      grn_r <= grn_nxt;
      blu_r <= blu_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = grn_r;
  assign out_blue  = blu_r;

endmodule

// ----- design/hsv_to_rgb_pixel.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// registers in order: front, terms stage two, terms stage three, quant
// throughput: one word per cycle while out_stall is low; every stage holds one
// word, moving on when the next stage has room; a stall loses and repeats nothing
// reset: synchronous active-low rst_n clears the valid bit of each stage
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_pixel_defines.svh"

module hsv_to_rgb_pixel #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_hue,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_saturation,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_brightness,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [hsv2rgb_pkg::RGB_W-1:0]  out_red,
  output logic        [hsv2rgb_pkg::RGB_W-1:0]  out_green,
  output logic        [hsv2rgb_pkg::RGB_W-1:0]  out_blue
);
  import hsv2rgb_pkg::*;

  // stage map
  //   front: clamp saturation and value to 0..1, hue times 3/pi (one multiply)
  //   terms: sector and fraction, s*f products, then v times those, sector routing
  //   quant: times 255 with round half up, output register
  // zero saturation needs no special path: p, q and t all collapse to v

  logic                   front_ready;
  logic                   s1_valid, s1_ready;
  logic signed [X_W-1:0]  s1_x;
  logic [FRAC_BITS:0]     s1_sat, s1_bri;
  logic                   s3_valid, s3_ready;
  logic [3*FRAC_BITS:0]   s3_red, s3_green, s3_blue;

  hsv2rgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (front_ready),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_x       (s1_x),
    .s1_sat     (s1_sat),
    .s1_bri     (s1_bri)
  );

  hsv2rgb_terms #(
    .FRAC_BITS (FRAC_BITS)
  ) u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_x     (s1_x),
    .s1_sat   (s1_sat),
    .s1_bri   (s1_bri),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_red   (s3_red),
    .s3_green (s3_green),
    .s3_blue  (s3_blue)
  );

  hsv2rgb_quant #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3_red    (s3_red),
    .s3_green  (s3_green),
    .s3_blue   (s3_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // the input is held off only while every stage is full
  assign in_stall = !front_ready;

  // backpressure only ever starts at a full, stalled output
  `HSV2RGB_ASSERT_IMP(a_stall_origin, clk, rst_n, in_stall, out_valid && out_stall)
  // an accepted word always lands in the first stage
  `HSV2RGB_ASSERT_NXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, s1_valid)

endmodule

// ----- bench/hsv_to_rgb_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_checker
// watches both channels of the hsv to rgb pipeline, works out the colour of
// every accepted input word and compares it with the output words in order
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_checker #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_hue,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_saturation,
  input  logic signed [hsv2rgb_pkg::CHAN_W-1:0] in_brightness,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic        [hsv2rgb_pkg::RGB_W-1:0]  out_red,
  input  logic        [hsv2rgb_pkg::RGB_W-1:0]  out_green,
  input  logic        [hsv2rgb_pkg::RGB_W-1:0]  out_blue,
  output int                                    n_fail,
  output int                                    n_checked,
  output int                                    n_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    logic [RGB_W-1:0]  red;
    logic [RGB_W-1:0]  green;
    logic [RGB_W-1:0]  blue;
  } pixel_due_t;

  pixel_due_t colours_due[$];

  // clamp to 0..1.0
  function automatic longint unsigned unit_clamp(input logic signed [CHAN_W-1:0] raw);
    longint sv;
    sv = longint'(raw);
    if (sv < 0) return 0;
    if (sv > (longint'(1) << FRAC_BITS)) return longint'(1) << FRAC_BITS;
    return longint'(unsigned'(sv));
  endfunction

  // channel in q(3*frac) scaled to 0..255, rounded half up
  function automatic logic [RGB_W-1:0] chan_byte(input longint unsigned c);
    longint unsigned r;
    r = (c * 255 + (64'd1 << (3 * FRAC_BITS - 1))) >> (3 * FRAC_BITS);
    if (r > 255) r = 255;
    return r[RGB_W-1:0];
  endfunction

  function automatic pixel_due_t hsv_colour(input logic signed [CHAN_W-1:0] h,
                                            input logic signed [CHAN_W-1:0] s_raw,
                                            input logic signed [CHAN_W-1:0] v_raw);
    longint unsigned one_fx, one2, s, v, f, ux, sec_raw, vq, p, q, t, r, g, b;
    longint          hx;
    sector_t         sec;
    pixel_due_t      res;
    one_fx = 64'd1 << FRAC_BITS;
    one2   = one_fx * one_fx;
    s      = unit_clamp(s_raw);
    v      = unit_clamp(v_raw);
    if (s == 0) begin
      r = v << (2 * FRAC_BITS);
      g = r;
      b = r;
    end else begin
      hx  = longint'(h) * longint'(THIRD_PI_Q24);
      sec = SEC_0;
      f   = 0;
      // negative hue and anything past sector five fall back to sector zero
      if (hx >= 0) begin
        ux      = longint'(unsigned'(hx));
        sec_raw = ux >> (FRAC_BITS + K_W);
        if (sec_raw <= 5) begin
          sec = sector_t'(sec_raw[2:0]);
          f   = (ux >> K_W) & (one_fx - 1);
        end
      end
      vq = v * one2;
      p  = v * (one_fx - s) * one_fx;
      q  = v * (one2 - s * f);
      t  = v * (one2 - s * (one_fx - f));
      case (sec)
        SEC_1: begin r = q;  g = vq; b = p;  end
        SEC_2: begin r = p;  g = vq; b = t;  end
        SEC_3: begin r = p;  g = q;  b = vq; end
        SEC_4: begin r = t;  g = p;  b = vq; end
        SEC_5: begin r = vq; g = p;  b = q;  end
        default: begin r = vq; g = t;  b = p;  end
      endcase
    end
    res.hue   = h;
    res.sat   = s_raw;
    res.bri   = v_raw;
    res.red   = chan_byte(r);
    res.green = chan_byte(g);
    res.blue  = chan_byte(b);
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_due_t due;
    if (rst_n) begin
      if (in_valid && !in_stall)
        colours_due.push_back(hsv_colour(in_hue, in_saturation, in_brightness));
      if (out_valid && !out_stall) begin
        if (colours_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: output word rgb %0d %0d %0d with nothing outstanding",
                     $realtime, out_red, out_green, out_blue);
        end else begin
          due = colours_due.pop_front();
          n_checked++;
          if (out_red !== due.red || out_green !== due.green || out_blue !== due.blue) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: hsv %0d %0d %0d: rgb %0d %0d %0d, wanted %0d %0d %0d",
                       $realtime, $signed(due.hue), $signed(due.sat), $signed(due.bri),
                       out_red, out_green, out_blue, due.red, due.green, due.blue);
          end
        end
      end
      n_pending = colours_due.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives hsv colours into hsv_to_rgb_pixel through four idle/stall phases,
// directed corner colours first, then biased random ones; the checker beside
// the block predicts every rgb word and counts mismatches
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 133;   // per phase, four phases

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [CHAN_W-1:0] in_hue;
  logic signed [CHAN_W-1:0] in_saturation;
  logic signed [CHAN_W-1:0] in_brightness;
  logic                     out_valid;
  logic                     out_stall;
  logic        [RGB_W-1:0]  out_red;
  logic        [RGB_W-1:0]  out_green;
  logic        [RGB_W-1:0]  out_blue;

  int n_fail;
  int n_checked;
  int n_pending;
  int n_sent;
  int idle_pct;
  int stall_pct;
  int cycle_count;

  hsv_to_rgb_pixel i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  hsv_to_rgb_pixel_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .n_fail        (n_fail),
    .n_checked     (n_checked),
    .n_pending     (n_pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver back-pressure, redrawn at every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: ends a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // one input word: optional idle gap, then hold the word until accepted
  task automatic send_pixel(input logic [CHAN_W-1:0] h,
                            input logic [CHAN_W-1:0] s,
                            input logic [CHAN_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    // in_stall read at the edge is the value the block saw
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [CHAN_W-1:0] h, s, v;
    int                pick, sec_k;
    idle_pct      = 0;
    stall_pct     = 0;
    n_sent        = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;

    // reset, released on a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners, no idling
    // hue in the middle of each of the six sectors; full saturation and value save the last
    send_pixel(16'sd2145,  16'sd4096, 16'sd4096);
    send_pixel(16'sd6434,  16'sd4096, 16'sd4096);
    send_pixel(16'sd10723, 16'sd4096, 16'sd4096);
    send_pixel(16'sd15013, 16'sd4096, 16'sd4096);
    send_pixel(16'sd19302, 16'sd4096, 16'sd4096);
    send_pixel(16'sd23591, 16'sd2048, 16'sd3000);
    // either side of the sector one boundary
    send_pixel(16'sd4289,  16'sd4096, 16'sd4096);
    send_pixel(16'sd4290,  16'sd4096, 16'sd4096);
    // hue past sector five and the largest hue fall back to sector zero
    send_pixel(16'sd27000, 16'sd3000, 16'sd4096);
    send_pixel(16'sh7fff,  16'sd4096, 16'sd4096);
    // negative hue, including the most negative
    send_pixel(-16'sd1000, 16'sd4096, 16'sd2000);
    send_pixel(16'sh8000,  16'sd4096, 16'sd4096);
    // grey: zero saturation, and saturation clamped up from negative
    send_pixel(16'sd5000,  16'sd0,    16'sd2048);
    send_pixel(16'sd5000,  16'sh8000, 16'sd4096);
    // tiny saturation is not grey
    send_pixel(16'sd9000,  16'sd1,    16'sd4096);
    // saturation and value above one clamp to one
    send_pixel(16'sd12000, 16'sd4097, 16'sh7fff);
    send_pixel(16'sd12000, 16'sh7fff, 16'sd4097);
    // value zero and below zero give black
    send_pixel(16'sd15000, 16'sd4096, 16'sd0);
    send_pixel(16'sd15000, 16'sd4096, 16'sh8000);
    // all ones, all zeros, and hue zero at full saturation and value
    send_pixel(16'shffff,  16'shffff, 16'shffff);
    send_pixel(16'sd0,     16'sd0,    16'sd0);
    send_pixel(16'sd0,     16'sd4096, 16'sd4096);

    // random colours, four pacing phases: none, sender gaps, receiver stalls,
    // both together
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        // hue mostly inside the six sectors, some anywhere, some on a boundary
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          h = CHAN_W'($urandom_range(0, 25735));
        end else if (pick < 8) begin
          h = CHAN_W'($urandom());
        end else begin
          sec_k = $urandom_range(1, 6);
          h = CHAN_W'((sec_k * 428932) / 100 + $urandom_range(0, 2) - 1);
        end
        // saturation: mostly legal, some grey, some tiny, some anything
        pick = $urandom_range(0, 9);
        if (pick < 6)
          s = CHAN_W'($urandom_range(0, 4096));
        else if (pick == 6)
          s = '0;
        else if (pick == 7)
          s = CHAN_W'($urandom_range(1, 3));
        else
          s = CHAN_W'($urandom());
        // value: mostly legal, the rest anything
        if ($urandom_range(0, 9) < 7)
          v = CHAN_W'($urandom_range(0, 4096));
        else
          v = CHAN_W'($urandom());
        send_pixel(h, s, v);
      end
    end
    in_valid <= 1'b0;

    // drain: let the receiver take everything, then wait out any strays
    stall_pct = 0;
    while (n_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d hsv words sent, %0d rgb words checked", n_sent, n_checked);
    $display("summary: corner colours plus random ones over four idle/stall phases");
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
